// ----- src/ffha_pkg.sv -----
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared constants, types and helpers for the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

    localparam int HEAP_WORDS = 4096;
    localparam int ADDR_W     = $clog2(HEAP_WORDS);
    localparam int MEM_BYTES  = 2 * HEAP_WORDS;
    localparam int WALK_LIMIT = MEM_BYTES + 2;
    localparam int STEP_W     = $clog2(WALK_LIMIT + 1);
    localparam int BA_W       = 18;

    localparam logic [16:0] MEM_BYTES_V = 17'(MEM_BYTES);
    localparam logic [15:0] HDR_BYTES   = 16'd4;
    localparam logic [16:0] MIN_SPLIT   = 17'd6;

    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    localparam int REG_IDX_W = 1;
    localparam logic [REG_IDX_W-1:0] REG_HEAP_BEGIN = 1'd0;
    localparam logic [REG_IDX_W-1:0] REG_HEAP_END   = 1'd1;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] request_size;
        logic [15:0] address;
    } ffha_req_t;

    typedef struct packed {
        logic [15:0] result_address;
        logic [15:0] result_size;
        logic        ok;
    } ffha_res_t;

    typedef struct packed {
        logic [15:0] heap_begin;
        logic [15:0] heap_end;
    } ffha_cfg_t;

    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [15:0]       wr_data;
    } ffha_mem_cmd_t;

    // word holding a byte address, wrapping at the memory size
    function automatic logic [ADDR_W-1:0] word_of(input logic [BA_W-1:0] x);
        return x[ADDR_W:1];
    endfunction

    function automatic logic [BA_W-1:0] ba_of16(input logic [15:0] x);
        return {{(BA_W-16){1'b0}}, x};
    endfunction

endpackage

// ----- src/ffha_ram.sv -----
// ----------------------------------------------------------------------------
// ffha_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ffha_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- src/ffha_engine.sv -----
// ----------------------------------------------------------------------------
// ffha_engine
// Request sequencer: layout, first-fit walk, split, merge and predecessor search
// over the header memory, at most one memory access per cycle.
// ----------------------------------------------------------------------------
module ffha_engine (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  ffha_pkg::ffha_cfg_t    cfg,
    input  logic                   start,
    input  ffha_pkg::ffha_req_t    req,
    output logic                   idle,
    output logic                   res_valid,
    input  logic                   res_ready,
    output ffha_pkg::ffha_res_t    res,
    output ffha_pkg::ffha_mem_cmd_t mem_cmd,
    input  logic [15:0]            mem_rd_data
);
    import ffha_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE, ST_LAY_HDR, ST_LAY_USED,
        ST_A_SPAN, ST_A_USED, ST_A_CHK, ST_A_TAIL_SPAN, ST_A_TAIL_USED, ST_A_HEAD, ST_A_SET,
        ST_R_CLR, ST_R_SPAN, ST_R_NEXT, ST_R_PUSED,
        ST_M_RD, ST_M_SPAN, ST_M_USED, ST_M_NSPAN, ST_RET,
        ST_Q_RD, ST_Q_WAIT, ST_DONE
    } state_t;

    typedef enum logic [1:0] {RET_ALLOC, RET_FREE, RET_DONE} ret_t;

    state_t            state_reg, state_next;
    ret_t              ret_reg, ret_next;
    logic [15:0]       req_reg, req_next;
    logic [16:0]       wanted_reg, wanted_next;
    logic [BA_W-1:0]   b_reg, b_next;
    logic [BA_W-1:0]   cur_reg, cur_next;
    logic [BA_W-1:0]   mx_reg, mx_next;
    logic [BA_W-1:0]   n_reg, n_next;
    logic [15:0]       sx_reg, sx_next;
    logic [15:0]       span_reg, span_next;
    logic [STEP_W-1:0] steps_reg, steps_next;
    logic              heap_ready_reg, heap_ready_next;
    logic              heap_present_reg, heap_present_next;
    logic [15:0]       first_block_reg, first_block_next;
    logic [15:0]       heap_limit_reg, heap_limit_next;
    ffha_res_t         res_reg, res_next;

    logic [16:0]       lim_clamp;
    logic [15:0]       lim_even;
    logic [15:0]       beg_even;
    logic [16:0]       size_even;
    logic [16:0]       rest_wide;
    logic [BA_W-1:0]   tail_addr;
    logic [BA_W-1:0]   link_b;
    logic [BA_W-1:0]   link_cur;
    logic [BA_W-1:0]   link_mx;
    logic [BA_W-1:0]   limit_wide;
    logic [BA_W-1:0]   first_wide;

    assign lim_clamp  = ({1'b0, cfg.heap_end} > MEM_BYTES_V) ? MEM_BYTES_V : {1'b0, cfg.heap_end};
    assign lim_even   = lim_clamp[15:0] & 16'hFFFE;
    assign beg_even   = cfg.heap_begin & 16'hFFFE;
    assign size_even  = ({1'b0, req.request_size} + 17'd1) & 17'h1FFFE;
    assign rest_wide  = {1'b0, span_reg} - wanted_reg;
    assign tail_addr  = b_reg + {{(BA_W-17){1'b0}}, wanted_reg};
    assign link_b     = b_reg + ba_of16(span_reg);
    assign link_cur   = cur_reg + ba_of16(mem_rd_data);
    assign link_mx    = mx_reg + ba_of16(mem_rd_data);
    assign limit_wide = ba_of16(heap_limit_reg);
    assign first_wide = ba_of16(first_block_reg);

    assign idle      = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);
    assign res       = res_reg;

    always_comb begin
        state_next        = state_reg;
        ret_next          = ret_reg;
        req_next          = req_reg;
        wanted_next       = wanted_reg;
        b_next            = b_reg;
        cur_next          = cur_reg;
        mx_next           = mx_reg;
        n_next            = n_reg;
        sx_next           = sx_reg;
        span_next         = span_reg;
        steps_next        = steps_reg;
        heap_ready_next   = heap_ready_reg;
        heap_present_next = heap_present_reg;
        first_block_next  = first_block_reg;
        heap_limit_next   = heap_limit_reg;
        res_next          = res_reg;
        mem_cmd           = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    req_next   = req.request_size;
                    res_next   = '{result_address: 16'd0, result_size: 16'd0, ok: 1'b1};
                    case (req.op)
                        OP_ALLOC: begin
                            wanted_next = size_even + 17'(HDR_BYTES);
                            if (req.request_size == 16'd0 || req.request_size == 16'hFFFF) begin
                                res_next.ok = 1'b0;
                                state_next  = ST_DONE;
                            end else if (!heap_ready_reg) begin
                                heap_ready_next = 1'b1;
                                heap_limit_next = lim_even;
                                if ({1'b0, lim_even} < ({1'b0, beg_even} + MIN_SPLIT)) begin
                                    heap_present_next = 1'b0;
                                    first_block_next  = 16'd0;
                                    res_next.ok       = 1'b0;
                                    state_next        = ST_DONE;
                                end else begin
                                    heap_present_next = 1'b1;
                                    first_block_next  = beg_even;
                                    state_next        = ST_LAY_HDR;
                                end
                            end else if (!heap_present_reg) begin
                                res_next.ok = 1'b0;
                                state_next  = ST_DONE;
                            end else begin
                                b_next     = first_wide;
                                steps_next = '0;
                                state_next = ST_A_SPAN;
                            end
                        end
                        OP_FREE: begin
                            b_next = ba_of16(req.address - HDR_BYTES);
                            if (req.address == 16'd0) begin
                                state_next = ST_DONE;
                            end else begin
                                state_next = ST_R_CLR;
                            end
                        end
                        OP_QUERY: begin
                            b_next     = ba_of16(req.address - HDR_BYTES);
                            state_next = ST_Q_RD;
                        end
                        default: begin
                            res_next.ok = 1'b0;
                            state_next  = ST_DONE;
                        end
                    endcase
                end
            end
            ST_LAY_HDR: begin
                mem_cmd.wr_en   = 1'b1;
                mem_cmd.wr_addr = word_of(first_wide);
                mem_cmd.wr_data = heap_limit_reg - first_block_reg;
                state_next      = ST_LAY_USED;
            end
            ST_LAY_USED: begin
                mem_cmd.wr_en   = 1'b1;
                mem_cmd.wr_addr = word_of(first_wide + BA_W'(2));
                mem_cmd.wr_data = 16'd0;
                b_next          = first_wide;
                steps_next      = '0;
                state_next      = ST_A_SPAN;
            end
            ST_A_SPAN: begin
                if (steps_reg == STEP_W'(WALK_LIMIT)) begin
                    res_next.ok = 1'b0;
                    state_next  = ST_DONE;
                end else begin
                    mem_cmd.rd_en   = 1'b1;
                    mem_cmd.rd_addr = word_of(b_reg);
                    state_next      = ST_A_USED;
                end
            end
            ST_A_USED: begin
                span_next       = mem_rd_data;
                mem_cmd.rd_en   = 1'b1;
                mem_cmd.rd_addr = word_of(b_reg + BA_W'(2));
                state_next      = ST_A_CHK;
            end
            ST_A_CHK: begin
                if (mem_rd_data == 16'd0 && {1'b0, span_reg} >= wanted_reg) begin
                    if (rest_wide >= MIN_SPLIT) begin
                        state_next = ST_A_TAIL_SPAN;
                    end else begin
                        state_next = ST_A_SET;
                    end
                end else if (link_b >= limit_wide) begin
                    res_next.ok = 1'b0;
                    state_next  = ST_DONE;
                end else begin
                    b_next     = link_b;
                    steps_next = steps_reg + STEP_W'(1);
                    state_next = ST_A_SPAN;
                end
            end
            ST_A_TAIL_SPAN: begin
                mem_cmd.wr_en   = 1'b1;
                mem_cmd.wr_addr = word_of(tail_addr);
                mem_cmd.wr_data = rest_wide[15:0];
                state_next      = ST_A_TAIL_USED;
            end
            ST_A_TAIL_USED: begin
                mem_cmd.wr_en   = 1'b1;
                mem_cmd.wr_addr = word_of(tail_addr + BA_W'(2));
                mem_cmd.wr_data = 16'd0;
                state_next      = ST_A_HEAD;
            end
            ST_A_HEAD: begin
                mem_cmd.wr_en   = 1'b1;
                mem_cmd.wr_addr = word_of(b_reg);
                mem_cmd.wr_data = wanted_reg[15:0];
                mx_next         = tail_addr;
                ret_next        = RET_ALLOC;
                state_next      = ST_M_RD;
            end
            ST_A_SET: begin
                mem_cmd.wr_en           = 1'b1;
                mem_cmd.wr_addr         = word_of(b_reg + BA_W'(2));
                mem_cmd.wr_data         = req_reg;
                res_next.result_address = b_reg[15:0] + HDR_BYTES;
                res_next.ok             = 1'b1;
                state_next              = ST_DONE;
            end
            ST_R_CLR: begin
                mem_cmd.wr_en   = 1'b1;
                mem_cmd.wr_addr = word_of(b_reg + BA_W'(2));
                mem_cmd.wr_data = 16'd0;
                mx_next         = b_reg;
                ret_next        = RET_FREE;
                state_next      = ST_M_RD;
            end
            ST_R_SPAN: begin
                if (steps_reg == STEP_W'(WALK_LIMIT)) begin
                    state_next = ST_DONE;
                end else begin
                    mem_cmd.rd_en   = 1'b1;
                    mem_cmd.rd_addr = word_of(cur_reg);
                    state_next      = ST_R_NEXT;
                end
            end
            ST_R_NEXT: begin
                if (link_cur >= limit_wide) begin
                    state_next = ST_DONE;
                end else if (link_cur == b_reg) begin
                    mem_cmd.rd_en   = 1'b1;
                    mem_cmd.rd_addr = word_of(cur_reg + BA_W'(2));
                    state_next      = ST_R_PUSED;
                end else begin
                    cur_next   = link_cur;
                    steps_next = steps_reg + STEP_W'(1);
                    state_next = ST_R_SPAN;
                end
            end
            ST_R_PUSED: begin
                if (mem_rd_data == 16'd0) begin
                    mx_next    = cur_reg;
                    ret_next   = RET_DONE;
                    state_next = ST_M_RD;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_M_RD: begin
                mem_cmd.rd_en   = 1'b1;
                mem_cmd.rd_addr = word_of(mx_reg);
                state_next      = ST_M_SPAN;
            end
            ST_M_SPAN: begin
                sx_next = mem_rd_data;
                if (link_mx >= limit_wide) begin
                    state_next = ST_RET;
                end else begin
                    n_next          = link_mx;
                    mem_cmd.rd_en   = 1'b1;
                    mem_cmd.rd_addr = word_of(link_mx + BA_W'(2));
                    state_next      = ST_M_USED;
                end
            end
            ST_M_USED: begin
                if (mem_rd_data != 16'd0) begin
                    state_next = ST_RET;
                end else begin
                    mem_cmd.rd_en   = 1'b1;
                    mem_cmd.rd_addr = word_of(n_reg);
                    state_next      = ST_M_NSPAN;
                end
            end
            ST_M_NSPAN: begin
                mem_cmd.wr_en   = 1'b1;
                mem_cmd.wr_addr = word_of(mx_reg);
                mem_cmd.wr_data = sx_reg + mem_rd_data;
                state_next      = ST_RET;
            end
            ST_RET: begin
                case (ret_reg)
                    RET_ALLOC: state_next = ST_A_SET;
                    RET_FREE: begin
                        if (heap_present_reg) begin
                            cur_next   = first_wide;
                            steps_next = '0;
                            state_next = ST_R_SPAN;
                        end else begin
                            state_next = ST_DONE;
                        end
                    end
                    default: state_next = ST_DONE;
                endcase
            end
            ST_Q_RD: begin
                mem_cmd.rd_en   = 1'b1;
                mem_cmd.rd_addr = word_of(b_reg + BA_W'(2));
                state_next      = ST_Q_WAIT;
            end
            ST_Q_WAIT: begin
                res_next.result_size = mem_rd_data;
                state_next           = ST_DONE;
            end
            ST_DONE: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            ret_reg          <= RET_DONE;
            heap_ready_reg   <= 1'b0;
            heap_present_reg <= 1'b0;
            first_block_reg  <= 16'd0;
            heap_limit_reg   <= 16'd0;
        end else begin
            state_reg        <= state_next;
            ret_reg          <= ret_next;
            heap_ready_reg   <= heap_ready_next;
            heap_present_reg <= heap_present_next;
            first_block_reg  <= first_block_next;
            heap_limit_reg   <= heap_limit_next;
        end
        req_reg    <= req_next;
        wanted_reg <= wanted_next;
        b_reg      <= b_next;
        cur_reg    <= cur_next;
        mx_reg     <= mx_next;
        n_reg      <= n_next;
        sx_reg     <= sx_next;
        span_reg   <= span_next;
        steps_reg  <= steps_next;
        res_reg    <= res_next;
    end

endmodule

// ----- src/first_fit_heap_allocator_unit.sv -----
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_unit
// Heap allocator over a word memory: allocate, free and size query requests.
// ----------------------------------------------------------------------------
// latency grows with the blocks walked: allocate lays out the heap on first use,
//   walks the blocks first-fit, then splits and merges the tail; free merges with
//   the next block, walks to the predecessor and merges into it if free
// throughput: one request at a time, the next accepted the cycle after the result
//   leaves the engine; the header walk does at most one memory access per cycle
// reset: control state, heap layout and output valid cleared; the heap memory
//   is not cleared and is laid out on the first allocate of a valid size
module first_fit_heap_allocator_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [ffha_pkg::REG_IDX_W-1:0] cfg_wr_index,
    input  logic [15:0]                    cfg_wr_data,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [31:0]                    s_tdata,  // request_size, address
    input  logic [1:0]                     s_tuser,  // op
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [31:0]                    m_tdata,  // result_address, result_size
    output logic                           m_tuser   // ok
);
    import ffha_pkg::*;

    ffha_cfg_t     cfg_reg;
    ffha_req_t     eng_req;
    ffha_res_t     eng_res;
    ffha_mem_cmd_t mem_cmd;
    logic [15:0]   mem_rd_data;
    logic          eng_idle;
    logic          res_valid;
    logic          res_ready;
    logic          m_tvalid_reg;
    ffha_res_t     out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                REG_HEAP_BEGIN: cfg_reg.heap_begin <= cfg_wr_data;
                REG_HEAP_END:   cfg_reg.heap_end   <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    assign eng_req = '{op: s_tuser, request_size: s_tdata[15:0], address: s_tdata[31:16]};
    assign s_tready = eng_idle;

    ffha_engine u_engine (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .start       (s_tvalid && eng_idle),
        .req         (eng_req),
        .idle        (eng_idle),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (eng_res),
        .mem_cmd     (mem_cmd),
        .mem_rd_data (mem_rd_data)
    );

    ffha_ram #(
        .WIDTH (16),
        .DEPTH (HEAP_WORDS)
    ) u_heap_ram (
        .aclk    (aclk),
        .wr_en   (mem_cmd.wr_en),
        .wr_addr (mem_cmd.wr_addr),
        .wr_data (mem_cmd.wr_data),
        .rd_en   (mem_cmd.rd_en),
        .rd_addr (mem_cmd.rd_addr),
        .rd_data (mem_rd_data)
    );

    // output register parts the result from the next request
    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_ready) begin
            m_tvalid_reg <= res_valid;
        end
        if (res_valid && res_ready) begin
            out_reg <= eng_res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {out_reg.result_size, out_reg.result_address};
    assign m_tuser  = out_reg.ok;

endmodule

// ----- tb/tb_first_fit_heap_allocator_unit.sv -----
// ----------------------------------------------------------------------------
// tb_first_fit_heap_allocator_unit
// Self-checking bench for the first-fit heap allocator. A shadow heap held in
// the bench tracks every accepted request and gives the reply it must cause.
// Each candidate request is first tried on a copy of the shadow heap so that
// no request ever touches a heap word that was never written. The heap bounds
// are latched on the first real allocate, so later register writes only check
// that they have no effect. Both sides idle at random, with one long receiver
// hold-off and one phase without idling.
// ----------------------------------------------------------------------------
module tb_first_fit_heap_allocator_unit;

    import ffha_pkg::*;

    localparam logic [1:0] OP_UNUSED  = 2'd3;
    localparam int unsigned WALK_SOFT = 400;
    localparam longint      RUN_LIMIT = 80_000_000;

    logic                 aclk;
    logic                 aresetn      = 1'b0;
    logic                 cfg_wr_en    = 1'b0;
    logic [REG_IDX_W-1:0] cfg_wr_index = REG_HEAP_BEGIN;
    logic [15:0]          cfg_wr_data  = 16'h0000;
    logic                 s_tvalid     = 1'b0;
    logic                 s_tready;
    logic [31:0]          s_tdata      = 32'h0;
    logic [1:0]           s_tuser      = OP_ALLOC;
    logic                 m_tvalid;
    logic                 m_tready     = 1'b0;
    logic [31:0]          m_tdata;
    logic                 m_tuser;

    first_fit_heap_allocator_unit uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser)
    );

    // shadow heap
    bit [15:0]   shadow_words [HEAP_WORDS];
    bit          shadow_known [HEAP_WORDS];
    bit [15:0]   heap_first;
    bit          heap_laid;
    bit          heap_exists;
    int unsigned heap_limit_b;
    bit [15:0]   reg_begin;
    bit [15:0]   reg_end;
    bit          stray_read;
    int unsigned walk_steps;
    int          long_walks_left = 3;

    ffha_req_t   req_q [$];
    ffha_req_t   on_bus;
    ffha_res_t   heap_replies [$];
    bit [15:0]   live_payloads [$];
    bit [15:0]   retired_payloads [$];
    int          issued_cnt;
    int          accepted_cnt;
    int          results_seen;
    int          bad_count;
    int          hold_left;
    bit          hold_done;
    bit          no_idle;

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic bit [15:0] peek(int unsigned a);
        int unsigned w;
        w = (a >> 1) % HEAP_WORDS;
        if (!shadow_known[w]) stray_read = 1'b1;
        return shadow_words[w];
    endfunction

    function automatic void poke(int unsigned a, bit [15:0] v);
        int unsigned w;
        w = (a >> 1) % HEAP_WORDS;
        shadow_words[w] = v;
        shadow_known[w] = 1'b1;
    endfunction

    function automatic bit step_on(int unsigned b, output int unsigned n);
        int unsigned a;
        walk_steps++;
        a = b + peek(b);
        n = a;
        return a < heap_limit_b;
    endfunction

    function automatic void merge_after(int unsigned b);
        int unsigned n;
        if (step_on(b, n)) begin
            if (peek(n + 2) == 16'h0) poke(b, peek(b) + peek(n));
        end
    endfunction

    function automatic void lay_out_heap();
        int unsigned lim, beg;
        if (heap_laid) return;
        heap_laid = 1'b1;
        lim = reg_end;
        if (lim > MEM_BYTES) lim = MEM_BYTES;
        lim[0] = 1'b0;
        beg = reg_begin;
        beg[0] = 1'b0;
        heap_limit_b = lim;
        if (lim < beg + MIN_SPLIT) begin
            heap_exists = 1'b0;
            heap_first = 16'h0;
            return;
        end
        heap_exists = 1'b1;
        heap_first = 16'(beg);
        poke(beg, 16'(lim - beg));
        poke(beg + 2, 16'h0);
    endfunction

    function automatic bit [15:0] grab_block(int unsigned req);
        int unsigned size, wanted, b, nb, span, rest, tail, steps;
        if (req == 0) return 16'h0;
        size = (req + 1) & 32'hFFFF_FFFE;
        if (size > 32'hFFFF) return 16'h0;
        lay_out_heap();
        if (!heap_exists) return 16'h0;
        wanted = HDR_BYTES + size;
        b = heap_first;
        for (steps = 0; steps < WALK_LIMIT; steps++) begin
            span = peek(b);
            if (peek(b + 2) == 16'h0 && span >= wanted) begin
                rest = span - wanted;
                if (rest >= MIN_SPLIT) begin
                    tail = b + wanted;
                    poke(tail, 16'(rest));
                    poke(tail + 2, 16'h0);
                    poke(b, 16'(wanted));
                    merge_after(tail);
                end
                poke(b + 2, 16'(req));
                return 16'(b + HDR_BYTES);
            end
            if (!step_on(b, nb)) return 16'h0;
            b = nb;
        end
        return 16'h0;
    endfunction

    function automatic void drop_block(int unsigned addr);
        int unsigned b, cur, n, steps;
        if (addr == 0) return;
        b = (addr - HDR_BYTES) & 32'hFFFF;
        poke(b + 2, 16'h0);
        merge_after(b);
        if (!heap_exists) return;
        cur = heap_first;
        for (steps = 0; steps < WALK_LIMIT; steps++) begin
            if (!step_on(cur, n)) return;
            if (n == b) begin
                if (peek(cur + 2) == 16'h0) merge_after(cur);
                return;
            end
            cur = n;
        end
    endfunction

    function automatic ffha_res_t serve_request(ffha_req_t r);
        ffha_res_t o;
        o.result_address = 16'h0;
        o.result_size    = 16'h0;
        o.ok             = 1'b1;
        case (r.op)
            OP_ALLOC: begin
                o.result_address = grab_block(r.request_size);
                o.ok = (o.result_address != 16'h0);
            end
            OP_FREE:  drop_block(r.address);
            OP_QUERY: o.result_size = peek(((32'(r.address) - HDR_BYTES) & 32'hFFFF) + 2);
            default:  o.ok = 1'b0;
        endcase
        return o;
    endfunction

    // run a request on the shadow heap and put everything back
    function automatic bit trial_ok(ffha_req_t r, output ffha_res_t o);
        bit [15:0]   keep_words [HEAP_WORDS];
        bit          keep_known [HEAP_WORDS];
        bit [15:0]   keep_first;
        bit          keep_laid, keep_exists;
        int unsigned keep_limit;
        keep_words  = shadow_words;
        keep_known  = shadow_known;
        keep_first  = heap_first;
        keep_laid   = heap_laid;
        keep_exists = heap_exists;
        keep_limit  = heap_limit_b;
        stray_read  = 1'b0;
        walk_steps  = 0;
        o = serve_request(r);
        shadow_words = keep_words;
        shadow_known = keep_known;
        heap_first   = keep_first;
        heap_laid    = keep_laid;
        heap_exists  = keep_exists;
        heap_limit_b = keep_limit;
        return !stray_read && (walk_steps <= WALK_SOFT || long_walks_left > 0);
    endfunction

    function automatic ffha_req_t mk_req(logic [1:0] op, logic [15:0] sz, logic [15:0] ad);
        ffha_req_t r;
        r.op           = op;
        r.request_size = sz;
        r.address      = ad;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        if (bad_count < 100)
            $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
        bad_count++;
    endtask

    task automatic set_reg(logic [REG_IDX_W-1:0] idx, logic [15:0] val);
        @(posedge aclk);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= val;
        if (idx == REG_HEAP_BEGIN) reg_begin = val;
        else reg_end = val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // one request at a time so the trial sees the heap as the block will
    task automatic offer(ffha_req_t r, output bit took);
        ffha_res_t o;
        do @(negedge aclk); while (issued_cnt != accepted_cnt);
        took = trial_ok(r, o);
        if (took) begin
            if (walk_steps > WALK_SOFT) long_walks_left--;
            if (r.op == OP_ALLOC && o.ok) live_payloads.push_back(o.result_address);
            req_q.push_back(r);
            issued_cnt++;
        end
    endtask

    task automatic drain();
        do @(negedge aclk); while (issued_cnt != accepted_cnt || heap_replies.size() != 0);
    endtask

    task automatic random_request();
        ffha_req_t   r;
        int unsigned pick, sub, idx;
        bit          took, from_live;
        took = 1'b0;
        while (!took) begin
            pick = $urandom_range(99);
            sub  = $urandom_range(99);
            idx  = 0;
            from_live = 1'b0;
            if (live_payloads.size() > 90 && pick < 42) pick = 50;
            if (live_payloads.size() == 0 && pick >= 42 && pick < 72) pick = 0;
            r = mk_req(OP_ALLOC, 16'($urandom), 16'($urandom));
            if (pick < 42) begin
                if (sub < 70) r.request_size = 16'($urandom_range(48, 1));
                else if (sub < 90) r.request_size = 16'($urandom_range(600, 49));
                else if (sub < 93) r.request_size = 16'($urandom_range(8190, 7000));
                else if (sub < 97) r.request_size = 16'($urandom);
                else if (sub < 98) r.request_size = 16'h0000;
                else r.request_size = 16'hFFFF;
            end else if (pick < 72) begin
                idx = $urandom_range(live_payloads.size() - 1);
                r.op = OP_FREE;
                r.address = live_payloads[idx];
                from_live = 1'b1;
            end else if (pick < 75) begin
                r.op = OP_FREE;
                r.address = 16'h0000;
            end else if (pick < 80) begin
                // double release or a stray address
                r.op = OP_FREE;
                if (sub < 50 && retired_payloads.size() > 0)
                    r.address = retired_payloads[$urandom_range(retired_payloads.size() - 1)];
            end else if (pick < 96) begin
                r.op = OP_QUERY;
                if (sub < 75 && live_payloads.size() > 0)
                    r.address = live_payloads[$urandom_range(live_payloads.size() - 1)]
                                ^ (16'($urandom_range(7)) << 13);
                else if (sub < 85 && retired_payloads.size() > 0)
                    r.address = retired_payloads[$urandom_range(retired_payloads.size() - 1)];
            end else begin
                r.op = OP_UNUSED;
            end
            offer(r, took);
            if (took && from_live) begin
                retired_payloads.push_back(live_payloads[idx]);
                live_payloads.delete(idx);
                if (retired_payloads.size() > 32) void'(retired_payloads.pop_front());
            end
        end
    endtask

    always @(posedge aclk) begin : feed
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                heap_replies.push_back(serve_request(on_bus));
                accepted_cnt++;
            end
            if (!s_tvalid || s_tready) begin
                if (req_q.size() != 0 && (no_idle || $urandom_range(99) >= 23)) begin
                    on_bus = req_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {on_bus.address, on_bus.request_size};
                    s_tuser  <= on_bus.op;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin : watch
        ffha_res_t got, want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.result_address = m_tdata[15:0];
                got.result_size    = m_tdata[31:16];
                got.ok             = m_tuser;
                if (heap_replies.size() == 0) begin
                    report_mismatch("unrequested result", got.result_address, 16'h0);
                end else begin
                    want = heap_replies.pop_front();
                    if (got.result_address !== want.result_address)
                        report_mismatch("result_address", got.result_address,
                                        want.result_address);
                    if (got.result_size !== want.result_size)
                        report_mismatch("result_size", got.result_size, want.result_size);
                    if (got.ok !== want.ok)
                        report_mismatch("ok", {15'h0, got.ok}, {15'h0, want.ok});
                end
                results_seen++;
            end
            // one long hold-off so the block backs up onto its request side
            if (hold_left > 0) begin
                hold_left--;
            end else if (results_seen >= 100 && !hold_done) begin
                hold_left = 400;
                hold_done = 1'b1;
            end
            m_tready <= (hold_left == 0) && (no_idle || $urandom_range(99) >= 23);
        end
    end

    initial begin : stimulus
        bit took;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // bounds that give no heap, untouched while nothing lays it out
        set_reg(REG_HEAP_BEGIN, 16'hFFFE);
        set_reg(REG_HEAP_END, 16'h0000);
        offer(mk_req(OP_ALLOC, 16'h0000, 16'hFFFF), took);
        offer(mk_req(OP_ALLOC, 16'hFFFF, 16'h0000), took);
        offer(mk_req(OP_UNUSED, 16'h0000, 16'h0000), took);
        offer(mk_req(OP_FREE, 16'hFFFF, 16'h0000), took);
        drain();

        // heap from address 0, end clamped to the memory size
        set_reg(REG_HEAP_BEGIN, 16'h0000);
        set_reg(REG_HEAP_END, 16'hFFFF);
        offer(mk_req(OP_ALLOC, 16'd10, 16'h0), took);
        offer(mk_req(OP_ALLOC, 16'd10, 16'h0), took);
        offer(mk_req(OP_ALLOC, 16'd10, 16'h0), took);
        offer(mk_req(OP_QUERY, 16'h0, 16'd18), took);
        offer(mk_req(OP_FREE, 16'h0, 16'd18), took);
        offer(mk_req(OP_ALLOC, 16'd8, 16'h0), took);    // fits without a split
        offer(mk_req(OP_QUERY, 16'h0, 16'd18), took);
        offer(mk_req(OP_FREE, 16'h0, 16'd4), took);
        offer(mk_req(OP_FREE, 16'h0, 16'd32), took);    // joins the free tail
        offer(mk_req(OP_FREE, 16'h0, 16'd18), took);    // joins both neighbours
        offer(mk_req(OP_QUERY, 16'h0, 16'd4), took);
        offer(mk_req(OP_ALLOC, 16'd8188, 16'h0), took); // whole heap
        offer(mk_req(OP_ALLOC, 16'd1, 16'h0), took);
        offer(mk_req(OP_FREE, 16'h0, 16'd4), took);
        offer(mk_req(OP_ALLOC, 16'd8189, 16'h0), took);
        offer(mk_req(OP_ALLOC, 16'hFFFE, 16'h0), took);
        offer(mk_req(OP_ALLOC, 16'hFFFF, 16'h0), took);
        offer(mk_req(OP_ALLOC, 16'h0000, 16'h0), took);
        offer(mk_req(OP_UNUSED, 16'hFFFF, 16'hFFFF), took);
        offer(mk_req(OP_FREE, 16'hFFFF, 16'h0000), took);
        live_payloads.delete();
        offer(mk_req(OP_ALLOC, 16'd1, 16'hFFFF), took);
        offer(mk_req(OP_QUERY, 16'h0, 16'd4), took);
        drain();

        for (int i = 0; i < 240; i++) begin
            if (i == 120) drain();
            random_request();
        end
        drain();

        // bounds are latched, so these must change nothing
        set_reg(REG_HEAP_BEGIN, 16'($urandom));
        set_reg(REG_HEAP_END, 16'($urandom));
        no_idle = 1'b1;
        for (int i = 0; i < 220; i++) random_request();
        drain();

        no_idle = 1'b0;
        set_reg(REG_HEAP_BEGIN, 16'hFFFE);
        set_reg(REG_HEAP_END, 16'h0000);
        for (int i = 0; i < 240; i++) random_request();
        drain();

        repeat (40) @(posedge aclk);
        if (bad_count == 0) begin
            $display("** first_fit_heap_allocator_unit: PASSED **");
        end else begin
            $display("** first_fit_heap_allocator_unit: FAILED **");
        end
        $finish;
    end

    initial begin : watchdog
        #(RUN_LIMIT);
        $display("** first_fit_heap_allocator_unit: FAILED **");
        $finish;
    end

endmodule
